/* sv/ffgr_pkg.sv */
package ffgr_pkg;

  // Widths of the item fields.
  localparam int DIM_W   = 3;
  localparam int COORD_W = 3;
  localparam int LEVEL_W = 8;
  localparam int TAG_W   = 3;

  // Opcodes of an input item.
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Palette tags, in the order the color pointer walks through them.
  localparam logic [TAG_W-1:0] TAG_WHITE  = 3'd0;
  localparam logic [TAG_W-1:0] TAG_RED    = 3'd1;
  localparam logic [TAG_W-1:0] TAG_GREEN  = 3'd2;
  localparam logic [TAG_W-1:0] TAG_BLUE   = 3'd3;
  localparam logic [TAG_W-1:0] TAG_PURPLE = 3'd4;

  localparam logic [LEVEL_W-1:0] COLOR_LEVEL_RESET = 8'd32;

  // Command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_PLACE_SCAN,
    KIND_PLACE_ZERO,
    KIND_PLACE_FAIL,
    KIND_READ,
    KIND_READ_OFF
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_EMIT
  } state_t;

  // Lit components of a palette entry: bit 2 red, bit 1 green, bit 0 blue.
  function automatic logic [2:0] palette_mask(input logic [TAG_W-1:0] tag);
    logic [2:0] m;
    unique case (tag)
      TAG_WHITE:  m = 3'b111;
      TAG_RED:    m = 3'b100;
      TAG_GREEN:  m = 3'b010;
      TAG_BLUE:   m = 3'b001;
      TAG_PURPLE: m = 3'b101;
      default:    m = 3'b111;
    endcase
    return m;
  endfunction

endpackage

/* sv/ffgr_front.sv */
module ffgr_front #(
  parameter int GRID_SIZE = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [ffgr_pkg::DIM_W-1:0]    in_rect_width,
  input  logic [ffgr_pkg::DIM_W-1:0]    in_rect_height,
  input  logic [ffgr_pkg::COORD_W-1:0]  in_cell_row,
  input  logic [ffgr_pkg::COORD_W-1:0]  in_cell_col,
  output logic                          cmd_valid,
  input  logic                          cmd_pop,
  output ffgr_pkg::cmd_t                cmd
);

  ffgr_pkg::cmd_t                 cls;
  ffgr_pkg::cmd_t                 q_r [ffgr_pkg::QDEPTH];
  logic [ffgr_pkg::QPW-1:0]       wr_ptr_r;
  logic [ffgr_pkg::QPW-1:0]       rd_ptr_r;
  logic [ffgr_pkg::QCW-1:0]       count_r;
  logic [ffgr_pkg::QCW-1:0]       count_nxt;
  logic                           push;

  // Sort the item into the work the back end has to do for it.
  always_comb begin
    cls.width  = in_rect_width;
    cls.height = in_rect_height;
    cls.row    = in_cell_row;
    cls.col    = in_cell_col;
    if (in_opcode == ffgr_pkg::OP_READ) begin
      if (int'(in_cell_row) < GRID_SIZE && int'(in_cell_col) < GRID_SIZE) begin
        cls.kind = ffgr_pkg::KIND_READ;
      end else begin
        cls.kind = ffgr_pkg::KIND_READ_OFF;
      end
    end else if (int'(in_rect_width) > GRID_SIZE || int'(in_rect_height) > GRID_SIZE) begin
      cls.kind = ffgr_pkg::KIND_PLACE_FAIL;
    end else if (in_rect_width == '0 || in_rect_height == '0) begin
      cls.kind = ffgr_pkg::KIND_PLACE_ZERO;
    end else begin
      cls.kind = ffgr_pkg::KIND_PLACE_SCAN;
    end
  end

  assign in_ready  = (count_r != ffgr_pkg::QCW'(ffgr_pkg::QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;

  always_comb begin
    count_nxt = count_r;
    case ({push, cmd_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* sv/ffgr_back.sv */
module ffgr_back #(
  parameter int GRID_SIZE = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  ffgr_pkg::cmd_t                cmd,
  input  logic [ffgr_pkg::LEVEL_W-1:0]  color_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_placed,
  output logic [ffgr_pkg::COORD_W-1:0]  out_origin_row,
  output logic [ffgr_pkg::COORD_W-1:0]  out_origin_col,
  output logic                          out_grid_full,
  output logic                          out_pixel_on,
  output logic [ffgr_pkg::LEVEL_W-1:0]  out_pixel_red,
  output logic [ffgr_pkg::LEVEL_W-1:0]  out_pixel_green,
  output logic [ffgr_pkg::LEVEL_W-1:0]  out_pixel_blue
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int RW    = $clog2(GRID_SIZE);
  localparam int IW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);

  ffgr_pkg::state_t               state_r;
  ffgr_pkg::state_t               state_nxt;

  logic [GRID_SIZE-1:0]           occ_r [GRID_SIZE];
  logic [ffgr_pkg::TAG_W-1:0]     tag_mem [CELLS];
  logic [ffgr_pkg::TAG_W-1:0]     tag_rd_r;
  logic [CW-1:0]                  cnt_r;
  logic [ffgr_pkg::TAG_W-1:0]     ptr_r;
  logic [ffgr_pkg::TAG_W-1:0]     ptr_nxt;
  logic                           out_valid_r;

  logic [ffgr_pkg::DIM_W-1:0]     w_r;
  logic [ffgr_pkg::DIM_W-1:0]     h_r;
  logic [RW-1:0]                  r0_r;
  logic [RW-1:0]                  c0_r;
  logic [RW-1:0]                  lim_r_r;
  logic [RW-1:0]                  lim_c_r;
  logic [RW-1:0]                  mr_r;
  logic [RW-1:0]                  mc_r;
  logic [RW-1:0]                  end_r_r;
  logic [RW-1:0]                  end_c_r;
  logic                           res_placed_r;
  logic                           rd_on_r;

  logic [GRID_SIZE-1:0]           col_mask;
  logic                           hit;
  logic                           scan_found;
  logic                           scan_last;
  logic                           mark_we;
  logic                           mark_done;
  logic                           adv_ptr;
  logic                           emit_load;
  logic [RW-1:0]                  rd_row;
  logic [RW-1:0]                  rd_col;
  logic [2:0]                     pmask;

  logic                           out_placed_r;
  logic [ffgr_pkg::COORD_W-1:0]   out_origin_row_r;
  logic [ffgr_pkg::COORD_W-1:0]   out_origin_col_r;
  logic                           out_grid_full_r;
  logic                           out_pixel_on_r;
  logic [ffgr_pkg::LEVEL_W-1:0]   out_pixel_red_r;
  logic [ffgr_pkg::LEVEL_W-1:0]   out_pixel_green_r;
  logic [ffgr_pkg::LEVEL_W-1:0]   out_pixel_blue_r;

  function automatic logic [IW-1:0] cell_idx(input logic [RW-1:0] r, input logic [RW-1:0] c);
    return IW'(int'(r) * GRID_SIZE + int'(c));
  endfunction

  assign rd_row = RW'(cmd.row);
  assign rd_col = RW'(cmd.col);

  // The candidate rectangle at (r0_r, c0_r) overlaps an occupied cell when any
  // row inside its height has a set bit under its column window.
  always_comb begin
    col_mask = '0;
    hit      = 1'b0;
    for (int j = 0; j < GRID_SIZE; j++) begin
      col_mask[j] = (j >= int'(c0_r)) && (j < int'(c0_r) + int'(w_r));
    end
    for (int j = 0; j < GRID_SIZE; j++) begin
      if (j >= int'(r0_r) && j < int'(r0_r) + int'(h_r)) begin
        hit = hit | (|(occ_r[j] & col_mask));
      end
    end
  end

  assign scan_last = (c0_r == lim_c_r) && (r0_r == lim_r_r);
  assign mark_done = (mc_r == end_c_r) && (mr_r == end_r_r);
  assign ptr_nxt   = (ptr_r == ffgr_pkg::TAG_PURPLE) ? ffgr_pkg::TAG_WHITE : ptr_r + 3'd1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffgr_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == ffgr_pkg::KIND_PLACE_SCAN) begin
            state_nxt = ffgr_pkg::ST_SCAN;
          end else begin
            state_nxt = ffgr_pkg::ST_EMIT;
          end
        end
      end
      ffgr_pkg::ST_SCAN: begin
        if (!hit) begin
          state_nxt = ffgr_pkg::ST_MARK;
        end else if (scan_last) begin
          state_nxt = ffgr_pkg::ST_EMIT;
        end
      end
      ffgr_pkg::ST_MARK: begin
        if (mark_done) begin
          state_nxt = ffgr_pkg::ST_EMIT;
        end
      end
      ffgr_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ffgr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffgr_pkg::ST_IDLE;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    cmd_pop    = (state_r == ffgr_pkg::ST_IDLE) && cmd_valid;
    scan_found = (state_r == ffgr_pkg::ST_SCAN) && !hit;
    mark_we    = (state_r == ffgr_pkg::ST_MARK);
    adv_ptr    = (mark_we && mark_done) ||
                 (cmd_pop && cmd.kind == ffgr_pkg::KIND_PLACE_ZERO);
    emit_load  = (state_r == ffgr_pkg::ST_EMIT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffgr_pkg::ST_IDLE;
      cnt_r       <= '0;
      ptr_r       <= ffgr_pkg::TAG_WHITE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < GRID_SIZE; i++) begin
        occ_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (mark_we) begin
        occ_r[mr_r][mc_r] <= 1'b1;
        cnt_r             <= cnt_r + 1'b1;
      end
      if (adv_ptr) begin
        ptr_r <= ptr_nxt;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Color tag store, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mark_we) begin
      tag_mem[cell_idx(mr_r, mc_r)] <= ptr_r;
    end
    if (cmd_pop && cmd.kind == ffgr_pkg::KIND_READ) begin
      tag_rd_r <= tag_mem[cell_idx(rd_row, rd_col)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      w_r          <= cmd.width;
      h_r          <= cmd.height;
      r0_r         <= '0;
      c0_r         <= '0;
      lim_r_r      <= RW'(GRID_SIZE) - RW'(cmd.height);
      lim_c_r      <= RW'(GRID_SIZE) - RW'(cmd.width);
      res_placed_r <= (cmd.kind == ffgr_pkg::KIND_PLACE_ZERO);
      rd_on_r      <= (cmd.kind == ffgr_pkg::KIND_READ) && occ_r[rd_row][rd_col];
    end else if (state_r == ffgr_pkg::ST_SCAN) begin
      if (scan_found) begin
        res_placed_r <= 1'b1;
        mr_r         <= r0_r;
        mc_r         <= c0_r;
        end_r_r      <= r0_r + RW'(h_r - 3'd1);
        end_c_r      <= c0_r + RW'(w_r - 3'd1);
      end else if (scan_last) begin
        r0_r <= '0;
        c0_r <= '0;
      end else if (c0_r == lim_c_r) begin
        c0_r <= '0;
        r0_r <= r0_r + 1'b1;
      end else begin
        c0_r <= c0_r + 1'b1;
      end
    end else if (mark_we) begin
      if (mc_r == end_c_r) begin
        mc_r <= c0_r;
        mr_r <= mr_r + 1'b1;
      end else begin
        mc_r <= mc_r + 1'b1;
      end
    end
  end

  assign pmask = ffgr_pkg::palette_mask(tag_rd_r);

  // Output register; it holds its item while the receiver stalls.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_placed_r     <= res_placed_r;
      out_origin_row_r <= res_placed_r ? ffgr_pkg::COORD_W'(r0_r) : '0;
      out_origin_col_r <= res_placed_r ? ffgr_pkg::COORD_W'(c0_r) : '0;
      out_grid_full_r  <= (cnt_r == CW'(CELLS));
      out_pixel_on_r   <= rd_on_r;
      out_pixel_red_r  <= (rd_on_r && pmask[2]) ? color_level : '0;
      out_pixel_green_r <= (rd_on_r && pmask[1]) ? color_level : '0;
      out_pixel_blue_r <= (rd_on_r && pmask[0]) ? color_level : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_placed      = out_placed_r;
  assign out_origin_row  = out_origin_row_r;
  assign out_origin_col  = out_origin_col_r;
  assign out_grid_full   = out_grid_full_r;
  assign out_pixel_on    = out_pixel_on_r;
  assign out_pixel_red   = out_pixel_red_r;
  assign out_pixel_green = out_pixel_green_r;
  assign out_pixel_blue  = out_pixel_blue_r;

endmodule

/* sv/first_fit_grid_rect_placer.sv */
// First-fit rectangle placer on a GRID_SIZE x GRID_SIZE occupancy grid.
// Input channel (in_valid/in_ready): an item with in_opcode place asks for a
// free in_rect_height x in_rect_width rectangle; an item with in_opcode read
// asks for the color of cell (in_cell_row, in_cell_col). Every item gives one
// result item on the output channel (out_valid/out_ready).
// A read goes from the command queue straight to the output register. A place
// first scans origins in row-major order (at most 25 on the default grid),
// checking one origin per cycle against the occupancy bitmap, then marks the
// cells of the rectangle, writing one cell per cycle to the color tag RAM,
// before its result is registered. Zero-size and oversize places and reads
// off the grid skip the scan and the marking.
// A two-item command queue sits in front of the engine, so new items are
// accepted while the engine works or while a result waits in the output
// register for a stalled receiver; in_ready drops only when that queue fills.
// cfg_wr_en/cfg_wr_data set the color level, applied when a cell is read.
// Reset (rst_n low, synchronous) empties the grid at once, sets the color
// pointer to white and the color level to 32; the tag RAM needs no clearing.
module first_fit_grid_rect_placer #(
  parameter int GRID_SIZE = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [ffgr_pkg::DIM_W-1:0]    in_rect_width,
  input  logic [ffgr_pkg::DIM_W-1:0]    in_rect_height,
  input  logic [ffgr_pkg::COORD_W-1:0]  in_cell_row,
  input  logic [ffgr_pkg::COORD_W-1:0]  in_cell_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_placed,
  output logic [ffgr_pkg::COORD_W-1:0]  out_origin_row,
  output logic [ffgr_pkg::COORD_W-1:0]  out_origin_col,
  output logic                          out_grid_full,
  output logic                          out_pixel_on,
  output logic [ffgr_pkg::LEVEL_W-1:0]  out_pixel_red,
  output logic [ffgr_pkg::LEVEL_W-1:0]  out_pixel_green,
  output logic [ffgr_pkg::LEVEL_W-1:0]  out_pixel_blue,
  input  logic                          cfg_wr_en,
  input  logic [ffgr_pkg::LEVEL_W-1:0]  cfg_wr_data
);

  logic [ffgr_pkg::LEVEL_W-1:0] color_level_r;
  logic                         cmd_valid;
  logic                         cmd_pop;
  ffgr_pkg::cmd_t               cmd;

  // Color level register. The user must write it only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_level_r <= ffgr_pkg::COLOR_LEVEL_RESET;
    end else if (cfg_wr_en) begin
      color_level_r <= cfg_wr_data;
    end
  end

  // The front end classifies each item (place with a scan, zero-size place,
  // oversize place, read, read off the grid) and queues it.
  ffgr_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd)
  );

  // The back end owns the grid, the tag RAM and the color pointer, and runs
  // one command at a time through scan, mark and result.
  ffgr_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop),
    .cmd             (cmd),
    .color_level     (color_level_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_placed      (out_placed),
    .out_origin_row  (out_origin_row),
    .out_origin_col  (out_origin_col),
    .out_grid_full   (out_grid_full),
    .out_pixel_on    (out_pixel_on),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue)
  );

`ifndef NO_ASSERTIONS
  // A place result never carries pixel data.
  a_place_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_placed |-> !out_pixel_on)
    else $error("place result has pixel_on set");

  // An empty or unread cell reports black.
  a_off_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_on |->
      out_pixel_red == '0 && out_pixel_green == '0 && out_pixel_blue == '0)
    else $error("pixel color without pixel_on");

  // The queue only pops what it holds.
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  // Reset restores the default color level.
  a_level_reset: assert property (@(posedge clk)
    !rst_n |=> color_level_r == ffgr_pkg::COLOR_LEVEL_RESET)
    else $error("color level not restored by reset");
`endif

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_W   = ffgr_pkg::DIM_W;
  localparam int COORD_W = ffgr_pkg::COORD_W;
  localparam int LEVEL_W = ffgr_pkg::LEVEL_W;
  localparam int TAG_W   = ffgr_pkg::TAG_W;

  // Grid edge length handed to the block; the predictor uses the same value.
  localparam int GRID = 5;
  // Cycles with no handshake on either channel before the run is declared hung.
  // The longest quiet stretch in a correct run is the receiver hold-off plus the
  // place commands waiting behind it, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 4000;
  // Length of the receiver hold-off that fills the command queue.
  localparam int HOLD_CYCLES = 300;
  // Cycles allowed after the last result so that a stray extra result shows up.
  localparam int DRAIN_CYCLES = 80;
  // Random items sent in each idling phase.
  localparam int PHASE_ITEMS = 270;

  typedef struct packed {
    logic               op;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } request_t;

  typedef struct packed {
    logic               placed;
    logic [COORD_W-1:0] origin_row;
    logic [COORD_W-1:0] origin_col;
    logic               grid_full;
    logic               pixel_on;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } response_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_opcode;
  logic [DIM_W-1:0]   in_rect_width;
  logic [DIM_W-1:0]   in_rect_height;
  logic [COORD_W-1:0] in_cell_row;
  logic [COORD_W-1:0] in_cell_col;
  logic               out_valid;
  logic               out_ready;
  logic               out_placed;
  logic [COORD_W-1:0] out_origin_row;
  logic [COORD_W-1:0] out_origin_col;
  logic               out_grid_full;
  logic               out_pixel_on;
  logic [LEVEL_W-1:0] out_pixel_red;
  logic [LEVEL_W-1:0] out_pixel_green;
  logic [LEVEL_W-1:0] out_pixel_blue;
  logic               cfg_wr_en;
  logic [LEVEL_W-1:0] cfg_wr_data;

  first_fit_grid_rect_placer #(
    .GRID_SIZE(GRID)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_placed     (out_placed),
    .out_origin_row (out_origin_row),
    .out_origin_col (out_origin_col),
    .out_grid_full  (out_grid_full),
    .out_pixel_on   (out_pixel_on),
    .out_pixel_red  (out_pixel_red),
    .out_pixel_green(out_pixel_green),
    .out_pixel_blue (out_pixel_blue),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  // Shadow copy of the block's state. The occupancy map starts empty, the
  // color pointer at white and the level at its reset value, as after reset.
  bit                 occupied [GRID][GRID];
  logic [TAG_W-1:0]   cell_tag [GRID][GRID];
  logic [TAG_W-1:0]   next_tag = ffgr_pkg::TAG_WHITE;
  logic [LEVEL_W-1:0] level = ffgr_pkg::COLOR_LEVEL_RESET;

  // Responses predicted for accepted items, oldest first.
  response_t pending_responses [$];

  // Idling knobs, in percent of cycles. The sender and receiver processes
  // read them; hold_left forces the receiver to stall for a counted stretch.
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  int fault_count = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Computes the response of the block to one item and updates the shadow
  // state. A place scans origins row by row, left to right, and takes the first
  // one whose whole rectangle is free; a zero-sized rectangle is always free at
  // the top-left corner, and a rectangle larger than the grid has no origin at
  // all. The color pointer moves on only when a place succeeds.
  function automatic response_t grid_response(request_t q);
    response_t a;
    bit found;
    bit clash;
    int r0, c0, r, c;
    a = '0;
    found = 1'b0;
    if (q.op == ffgr_pkg::OP_PLACE) begin
      if (q.w <= GRID && q.h <= GRID) begin
        for (r0 = 0; !found && r0 + q.h <= GRID; r0++) begin
          for (c0 = 0; !found && c0 + q.w <= GRID; c0++) begin
            clash = 1'b0;
            for (r = 0; r < q.h; r++)
              for (c = 0; c < q.w; c++)
                if (occupied[r0 + r][c0 + c]) clash = 1'b1;
            if (!clash) begin
              found = 1'b1;
              a.origin_row = COORD_W'(r0);
              a.origin_col = COORD_W'(c0);
            end
          end
        end
      end
      if (found) begin
        for (r = 0; r < q.h; r++)
          for (c = 0; c < q.w; c++) begin
            occupied[a.origin_row + r][a.origin_col + c] = 1'b1;
            cell_tag[a.origin_row + r][a.origin_col + c] = next_tag;
          end
        a.placed = 1'b1;
        next_tag = (next_tag == ffgr_pkg::TAG_PURPLE) ? ffgr_pkg::TAG_WHITE : next_tag + 1'b1;
      end
    end else if (q.row < GRID && q.col < GRID && occupied[q.row][q.col]) begin
      // The level is applied at read time, so older cells follow a new level.
      a.pixel_on = 1'b1;
      case (cell_tag[q.row][q.col])
        ffgr_pkg::TAG_WHITE: begin
          a.red = level;
          a.green = level;
          a.blue = level;
        end
        ffgr_pkg::TAG_RED:   a.red = level;
        ffgr_pkg::TAG_GREEN: a.green = level;
        ffgr_pkg::TAG_BLUE:  a.blue = level;
        ffgr_pkg::TAG_PURPLE: begin
          a.red = level;
          a.blue = level;
        end
        default: ;
      endcase
    end
    a.grid_full = 1'b1;
    foreach (occupied[i, j])
      if (!occupied[i][j]) a.grid_full = 1'b0;
    return a;
  endfunction

  function automatic request_t place_req(int w, int h);
    request_t q;
    q = '0;
    q.op = ffgr_pkg::OP_PLACE;
    q.w = DIM_W'(w);
    q.h = DIM_W'(h);
    return q;
  endfunction

  function automatic request_t read_req(int row, int col);
    request_t q;
    q = '0;
    q.op = ffgr_pkg::OP_READ;
    q.row = COORD_W'(row);
    q.col = COORD_W'(col);
    return q;
  endfunction

  // Random item: mostly small rectangles so the grid fills in many steps,
  // now and then any size up to the field limit, and reads that mostly land
  // on the grid. Unused fields carry random values as well.
  function automatic request_t random_request();
    request_t q;
    q.op = ($urandom_range(99) < 40) ? ffgr_pkg::OP_READ : ffgr_pkg::OP_PLACE;
    q.w = DIM_W'(($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2));
    q.h = DIM_W'(($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2));
    q.row = COORD_W'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                : $urandom_range(GRID - 1));
    q.col = COORD_W'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                : $urandom_range(GRID - 1));
    return q;
  endfunction

  // Offers one item, with random idle cycles in front of it, and returns at
  // the rising edge where it is accepted. Valid stays high afterwards; the next
  // call offers a new item or idles, or a drain lowers it, at a later falling edge.
  task automatic send_item(request_t q);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= q.op;
    in_rect_width <= q.w;
    in_rect_height <= q.h;
    in_cell_row <= q.row;
    in_cell_col <= q.col;
    pending_responses.push_back(grid_response(q));
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering items and waits until every predicted response has come.
  // Each item gives exactly one response, so the block is idle afterwards.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
  endtask

  task automatic set_color_level(input logic [LEVEL_W-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    level = v;
  endtask

  // The receiver process samples the knobs at falling edges, so they change
  // only right after a rising edge.
  task automatic set_idling(int idle, int stall);
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  // Empty grid: reads on and off the grid, oversize rectangles in either
  // direction, and zero-sized rectangles, which succeed without marking.
  task automatic test_empty_grid();
    send_item(read_req(0, 0));
    send_item(read_req(7, 7));
    send_item(read_req(5, 2));
    send_item(read_req(2, 5));
    send_item(place_req(6, 1));
    send_item(place_req(1, 6));
    send_item(place_req(7, 7));
    send_item(place_req(0, 3));
    send_item(place_req(4, 0));
    send_item(place_req(0, 0));
  endtask

  // First-fit placements that use every palette color, a request that finds
  // no room although it fits the grid, and reads of each color.
  task automatic test_first_fit();
    send_item(place_req(5, 2));
    send_item(place_req(3, 2));
    send_item(place_req(2, 1));
    send_item(place_req(1, 1));
    send_item(place_req(2, 2));
    send_item(place_req(1, 1));
    send_item(read_req(0, 4));
    send_item(read_req(3, 0));
    send_item(read_req(2, 4));
    send_item(read_req(3, 3));
    send_item(read_req(3, 4));
    send_item(read_req(4, 4));
  endtask

  // The level extremes applied to cells that were placed before the change.
  task automatic test_color_level();
    set_color_level(8'd255);
    send_item(read_req(0, 0));
    send_item(read_req(2, 0));
    send_item(read_req(2, 3));
    send_item(read_req(3, 3));
    send_item(read_req(3, 4));
    send_item(read_req(4, 0));
    set_color_level(8'd0);
    send_item(read_req(0, 0));
    send_item(read_req(2, 0));
    send_item(read_req(2, 3));
    send_item(read_req(3, 3));
    send_item(read_req(3, 4));
    set_color_level(ffgr_pkg::COLOR_LEVEL_RESET);
  endtask

  // The receiver stalls for a long counted stretch while the sender keeps
  // offering, so the output register and command queue fill and in_ready drops.
  task automatic test_backpressure();
    wait_drained();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (12) send_item(random_request());
    wait_drained();
  endtask

  // Random items in four idling phases, with a new color level each phase.
  task automatic test_random();
    int idle_of [4] = '{0, 56, 0, 19};
    int stall_of [4] = '{0, 0, 56, 19};
    for (int p = 0; p < 4; p++) begin
      set_color_level((p == 0) ? 8'd255 : (p == 1) ? 8'd0 : 8'($urandom_range(255)));
      set_idling(idle_of[p], stall_of[p]);
      repeat (PHASE_ITEMS) send_item(random_request());
    end
    wait_drained();
    set_idling(0, 0);
  endtask

  // Receiver: random stalls by stall_pct, or a forced stall while hold_left
  // counts down.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Response checker: every accepted response must match the oldest
  // prediction in every field.
  always @(posedge clk) begin : check_responses
    response_t seen;
    response_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_placed, out_origin_row, out_origin_col, out_grid_full,
               out_pixel_on, out_pixel_red, out_pixel_green, out_pixel_blue};
      if (pending_responses.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: response with none expected: %p", $realtime, seen);
        fault_count++;
      end else begin
        want = pending_responses.pop_front();
        if (seen.placed !== want.placed || seen.origin_row !== want.origin_row ||
            seen.origin_col !== want.origin_col || seen.grid_full !== want.grid_full ||
            seen.pixel_on !== want.pixel_on || seen.red !== want.red ||
            seen.green !== want.green || seen.blue !== want.blue) begin
          if (fault_count < 10)
            $display("%0t: response mismatch\n  expected %p\n  actual   %p",
                     $realtime, want, seen);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = ffgr_pkg::OP_PLACE;
    in_rect_width = '0;
    in_rect_height = '0;
    in_cell_row = '0;
    in_cell_col = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_grid();
    test_first_fit();
    test_color_level();
    test_backpressure();
    test_random();

    // Everything has been accepted; let the last responses arrive and give a
    // stray extra response time to show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
